// ===== hdl/raidmap_pkg.sv =====
// Shared types, codes and widths for the RAID stripe layout sector map.
// Used by the divider cells, the sector calculator and the top level.
package raidmap_pkg;

    // Parameter defaults for the top level.
    localparam int MAX_DISKS_DEF   = 16;
    localparam int STRIPE_BITS_DEF = 32;

    // Fixed field widths.
    localparam int STRIPE_IN_W = 32;
    localparam int DISK_W      = 4;
    localparam int SECTOR_W    = 37;
    localparam int STATUS_W    = 2;
    localparam int LEVEL_W     = 3;
    localparam int COUNT_W     = 5;
    localparam int CHUNK_W     = 11;

    // Chunk limits and datapath widths derived from them.
    localparam int CHUNK_MAX = 1024;
    localparam int DIV_W     = 11;  // divisor: chunk size or disk count
    localparam int REM_W     = 10;  // remainder stays below the divisor
    localparam int NC_W      = 15;  // disks times chunk, at most 31 * 1024
    localparam int ADD_W     = 16;  // offset plus chunk times disk

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes.
    localparam logic [1:0] REG_LEVEL = 2'd0;
    localparam logic [1:0] REG_DISKS = 2'd1;
    localparam logic [1:0] REG_CHUNK = 2'd2;

    // Layout codes.
    localparam logic [LEVEL_W-1:0] LVL_RAID0  = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_RAID01 = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_RAID10 = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_RAID4  = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_RAID5  = 3'd4;

    // Cell status codes.
    localparam logic [STATUS_W-1:0] ST_DATA    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PARITY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    // Control and side data handed from one divider cell to the next.
    typedef struct packed {
        logic              valid;
        logic [DISK_W-1:0] disk;
        logic [REM_W-1:0]  rem;
    } cell_side_t;

    // Effective configuration seen by the sector calculator.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] disks;
        logic [CHUNK_W-1:0] chunk;
        logic [NC_W-1:0]    disks_x_chunk;
        logic [NC_W-1:0]    disks_x_last;
    } map_cfg_t;

endpackage

// ===== hdl/raidmap_div_cell.sv =====
// One cell of the restoring divider chain: takes one dividend bit per word.
// Depends on raidmap_pkg for the side data struct and widths.
module raidmap_div_cell #(
    parameter int SB = raidmap_pkg::STRIPE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [raidmap_pkg::DIV_W-1:0] divisor,
    input  raidmap_pkg::cell_side_t       side_in,
    input  logic [SB-1:0]                 word_in,
    output raidmap_pkg::cell_side_t       side_out,
    output logic [SB-1:0]                 word_out
);

    logic                          valid_reg;
    logic [raidmap_pkg::DISK_W-1:0] disk_reg;
    logic [raidmap_pkg::REM_W-1:0]  rem_reg;
    logic [SB-1:0]                 word_reg;

    logic [raidmap_pkg::DIV_W-1:0] trial;
    logic [raidmap_pkg::DIV_W-1:0] diff;
    logic                          qbit;
    logic [raidmap_pkg::REM_W-1:0] rem_next;
    logic [SB-1:0]                 word_next;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        trial     = {side_in.rem, word_in[SB-1]};
        diff      = trial - divisor;
        qbit      = (trial >= divisor);
        rem_next  = qbit ? diff[raidmap_pkg::REM_W-1:0] : trial[raidmap_pkg::REM_W-1:0];
        word_next = {word_in[SB-2:0], qbit};
    end

    // The cell register; only the valid bit is reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= side_in.valid;
            disk_reg  <= side_in.disk;
            rem_reg   <= rem_next;
            word_reg  <= word_next;
        end
    end

    assign side_out.valid = valid_reg;
    assign side_out.disk  = disk_reg;
    assign side_out.rem   = rem_reg;
    assign word_out       = word_reg;

endmodule

// ===== hdl/raidmap_calc.sv =====
// Sector calculator: layout decode and multiply, then final add into the output register.
// Depends on raidmap_pkg for codes, widths and the configuration struct.
module raidmap_calc #(
    parameter int SB = raidmap_pkg::STRIPE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  raidmap_pkg::map_cfg_t            cfg,
    input  raidmap_pkg::cell_side_t          side_in,
    input  logic [SB-1:0]                    quot_in,
    output logic                             a_valid,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic [raidmap_pkg::SECTOR_W-1:0] m_sector_number,
    output logic [raidmap_pkg::STATUS_W-1:0] m_cell_status
);

    localparam int PW = SB + raidmap_pkg::NC_W;

    logic                             a_valid_reg;
    logic [PW-1:0]                    a_prod_reg;
    logic [raidmap_pkg::ADD_W-1:0]    a_add_reg;
    logic [raidmap_pkg::STATUS_W-1:0] a_status_reg;

    logic                             m_valid_reg;
    logic [raidmap_pkg::SECTOR_W-1:0] m_sector_reg;
    logic [raidmap_pkg::STATUS_W-1:0] m_status_reg;

    logic [raidmap_pkg::NC_W-1:0]     mult_next;
    logic [raidmap_pkg::ADD_W-1:0]    add_next;
    logic [raidmap_pkg::STATUS_W-1:0] status_next;
    logic [PW-1:0]                    prod_next;

    logic [raidmap_pkg::COUNT_W-1:0]  dd;
    logic [raidmap_pkg::COUNT_W-1:0]  half;
    logic [raidmap_pkg::COUNT_W-1:0]  last;
    logic [raidmap_pkg::COUNT_W-1:0]  r;
    logic [raidmap_pkg::COUNT_W-1:0]  pdisk;
    logic [raidmap_pkg::COUNT_W:0]    rot;
    logic [raidmap_pkg::COUNT_W-1:0]  col;
    logic [raidmap_pkg::SECTOR_W-1:0] sum;

    // Layout decode: pick the row multiplier, the in-row offset and the status.
    always_comb begin
        dd    = raidmap_pkg::COUNT_W'(side_in.disk);
        half  = cfg.disks >> 1;
        last  = cfg.disks - 5'd1;
        r     = side_in.rem[raidmap_pkg::COUNT_W-1:0];
        pdisk = last - r;
        rot   = {1'b0, dd} + {1'b0, r};
        if (rot >= {1'b0, cfg.disks}) begin
            rot = rot - {1'b0, cfg.disks};
        end
        col = (dd < half) ? dd : (dd - half);

        mult_next   = '0;
        add_next    = '0;
        status_next = raidmap_pkg::ST_DATA;
        if (dd >= cfg.disks) begin
            status_next = raidmap_pkg::ST_INVALID;
        end else begin
            unique case (cfg.level)
                raidmap_pkg::LVL_RAID0: begin
                    mult_next = cfg.disks_x_chunk;
                    add_next  = raidmap_pkg::ADD_W'(side_in.rem)
                              + raidmap_pkg::ADD_W'(cfg.chunk)
                              * raidmap_pkg::ADD_W'(side_in.disk);
                end
                raidmap_pkg::LVL_RAID01: begin
                    mult_next = raidmap_pkg::NC_W'(half);
                    add_next  = raidmap_pkg::ADD_W'(col);
                end
                raidmap_pkg::LVL_RAID10: begin
                    mult_next = raidmap_pkg::NC_W'(half);
                    add_next  = raidmap_pkg::ADD_W'(dd >> 1);
                end
                raidmap_pkg::LVL_RAID4: begin
                    if (dd == last) begin
                        status_next = raidmap_pkg::ST_PARITY;
                    end else begin
                        mult_next = raidmap_pkg::NC_W'(last);
                        add_next  = raidmap_pkg::ADD_W'(dd);
                    end
                end
                raidmap_pkg::LVL_RAID5: begin
                    // The chain gives the stripe over the disk count, so the row
                    // term is split into quotient and remainder shares.
                    if (dd == pdisk) begin
                        status_next = raidmap_pkg::ST_PARITY;
                    end else begin
                        mult_next = cfg.disks_x_last;
                        add_next  = raidmap_pkg::ADD_W'(r) * raidmap_pkg::ADD_W'(last)
                                  + raidmap_pkg::ADD_W'(rot);
                    end
                end
                default: begin
                    status_next = raidmap_pkg::ST_INVALID;
                end
            endcase
        end
        prod_next = PW'(quot_in) * PW'(mult_next);
    end

    // Multiply stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg  <= side_in.valid;
            a_prod_reg   <= prod_next;
            a_add_reg    <= add_next;
            a_status_reg <= status_next;
        end
    end

    // Final add, kept to the sector width.
    always_comb begin
        sum = raidmap_pkg::SECTOR_W'(a_prod_reg) + raidmap_pkg::SECTOR_W'(a_add_reg);
    end

    // Output register: loads when a word arrives, empties when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en && a_valid_reg) begin
            m_valid_reg  <= 1'b1;
            m_sector_reg <= sum;
            m_status_reg <= a_status_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign a_valid         = a_valid_reg;
    assign m_valid         = m_valid_reg;
    assign m_sector_number = m_sector_reg;
    assign m_cell_status   = m_status_reg;

endmodule

// ===== hdl/raid_layout_sector_map.sv =====
// Top level of the RAID stripe layout sector map: register port, divider chain, calculator.
// Depends on raidmap_pkg, raidmap_div_cell and raidmap_calc.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_stripe_index, s_disk_index
//  m_        out        m_valid/m_ready    m_sector_number, m_cell_status
//  apb       in         psel/penable       paddr, pwdata, prdata
//
// One word is accepted per cycle unless the pipeline is held. A word passes through
// the divider chain (one quotient bit per cell), then the multiply stage and the
// output register. Reset needs no clearing pass; there is no memory.
// A stalled output word halts the pipeline only when the stage behind it is
// also full, so bubbles are squeezed out and input is taken meanwhile.
module raid_layout_sector_map #(
    parameter int MAX_DISKS   = raidmap_pkg::MAX_DISKS_DEF,
    parameter int STRIPE_BITS = raidmap_pkg::STRIPE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [raidmap_pkg::STRIPE_IN_W-1:0] s_stripe_index,
    input  logic [raidmap_pkg::DISK_W-1:0]      s_disk_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [raidmap_pkg::SECTOR_W-1:0]    m_sector_number,
    output logic [raidmap_pkg::STATUS_W-1:0]    m_cell_status,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [raidmap_pkg::ADDR_W-1:0]      paddr,
    input  logic [raidmap_pkg::DATA_W-1:0]      pwdata,
    output logic [raidmap_pkg::DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int SB     = (STRIPE_BITS < raidmap_pkg::STRIPE_IN_W) ?
                            STRIPE_BITS : raidmap_pkg::STRIPE_IN_W;
    localparam int NCLAMP = (MAX_DISKS > 31) ? 31 : MAX_DISKS;

    logic [raidmap_pkg::LEVEL_W-1:0] cfg_level_reg;
    logic [raidmap_pkg::COUNT_W-1:0] cfg_disks_reg;
    logic [raidmap_pkg::CHUNK_W-1:0] cfg_chunk_reg;
    logic [raidmap_pkg::NC_W-1:0]    nc_reg;
    logic [raidmap_pkg::NC_W-1:0]    nc_next;
    logic [raidmap_pkg::NC_W-1:0]    nl_reg;
    logic [raidmap_pkg::NC_W-1:0]    nl_next;

    logic [raidmap_pkg::COUNT_W-1:0] disks_eff;
    logic [raidmap_pkg::CHUNK_W-1:0] chunk_eff;
    logic [raidmap_pkg::DIV_W-1:0]   divisor;
    logic [1:0]                      reg_index;
    logic                            wr_en;
    logic                            advance;
    logic                            a_valid;
    raidmap_pkg::map_cfg_t           map_cfg;

    raidmap_pkg::cell_side_t side_w [0:SB];
    logic [SB-1:0]           word_w [0:SB];

    // Register port: writes land on the access phase, reads are combinational.
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_level_reg <= raidmap_pkg::LVL_RAID0;
            cfg_disks_reg <= 5'd2;
            cfg_chunk_reg <= 11'd1;
        end else if (wr_en) begin
            unique case (reg_index)
                raidmap_pkg::REG_LEVEL: cfg_level_reg <= pwdata[raidmap_pkg::LEVEL_W-1:0];
                raidmap_pkg::REG_DISKS: cfg_disks_reg <= pwdata[raidmap_pkg::COUNT_W-1:0];
                raidmap_pkg::REG_CHUNK: cfg_chunk_reg <= pwdata[raidmap_pkg::CHUNK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            raidmap_pkg::REG_LEVEL: prdata = raidmap_pkg::DATA_W'(cfg_level_reg);
            raidmap_pkg::REG_DISKS: prdata = raidmap_pkg::DATA_W'(cfg_disks_reg);
            raidmap_pkg::REG_CHUNK: prdata = raidmap_pkg::DATA_W'(cfg_chunk_reg);
            default:                prdata = '0;
        endcase
    end

    // Clamp the disk count and chunk size into their working ranges.
    always_comb begin
        disks_eff = (int'(cfg_disks_reg) > NCLAMP) ?
                    raidmap_pkg::COUNT_W'(NCLAMP) : cfg_disks_reg;
        if (cfg_chunk_reg == '0) begin
            chunk_eff = 11'd1;
        end else if (int'(cfg_chunk_reg) > raidmap_pkg::CHUNK_MAX) begin
            chunk_eff = raidmap_pkg::CHUNK_W'(raidmap_pkg::CHUNK_MAX);
        end else begin
            chunk_eff = cfg_chunk_reg;
        end
    end

    // Row strides for chunked striping and for rotating parity, held in registers.
    assign nc_next = raidmap_pkg::NC_W'(raidmap_pkg::NC_W'(disks_eff)
                                        * raidmap_pkg::NC_W'(chunk_eff));
    assign nl_next = raidmap_pkg::NC_W'(raidmap_pkg::NC_W'(disks_eff)
                                        * raidmap_pkg::NC_W'(disks_eff - 5'd1));

    always_ff @(posedge aclk) begin
        nc_reg <= nc_next;
        nl_reg <= nl_next;
    end

    // The divider splits the stripe by the chunk for raid0, by the disk count for raid5.
    always_comb begin
        if (cfg_level_reg == raidmap_pkg::LVL_RAID0) begin
            divisor = raidmap_pkg::DIV_W'(chunk_eff);
        end else if (cfg_level_reg == raidmap_pkg::LVL_RAID5) begin
            divisor = raidmap_pkg::DIV_W'(disks_eff);
        end else begin
            divisor = raidmap_pkg::DIV_W'(1);
        end
    end

    assign map_cfg.level         = cfg_level_reg;
    assign map_cfg.disks         = disks_eff;
    assign map_cfg.chunk         = chunk_eff;
    assign map_cfg.disks_x_chunk = nc_reg;
    assign map_cfg.disks_x_last  = nl_reg;

    // The pipeline moves unless the output word is stalled with a word right behind it.
    assign advance = !(m_valid && !m_ready && a_valid);
    assign s_ready = advance;

    // Divider chain, most significant stripe bit first.
    assign side_w[0].valid = s_valid;
    assign side_w[0].disk  = s_disk_index;
    assign side_w[0].rem   = '0;
    assign word_w[0]       = s_stripe_index[SB-1:0];

    for (genvar k = 0; k < SB; k++) begin : g_cell
        raidmap_div_cell #(
            .SB(SB)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (advance),
            .divisor (divisor),
            .side_in (side_w[k]),
            .word_in (word_w[k]),
            .side_out(side_w[k+1]),
            .word_out(word_w[k+1])
        );
    end

    raidmap_calc #(
        .SB(SB)
    ) u_calc (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (advance),
        .cfg            (map_cfg),
        .side_in        (side_w[SB]),
        .quot_in        (word_w[SB]),
        .a_valid        (a_valid),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_sector_number(m_sector_number),
        .m_cell_status  (m_cell_status)
    );

    // Input is refused only when the output word and the stage behind it are both held.
    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid |-> s_ready)
        else $error("input refused while the multiply stage is empty");

    // An accepted word shows up in the first divider cell.
    a_accept_enters_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> side_w[1].valid)
        else $error("accepted word missing from the first cell");

    // A held pipeline keeps the word at the end of the chain.
    a_hold_freezes_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(side_w[SB].valid))
        else $error("divider chain moved during a stall");

    // Parity and invalid cells carry no sector number.
    a_non_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_cell_status != raidmap_pkg::ST_DATA) |-> (m_sector_number == '0))
        else $error("non-data cell with a nonzero sector");

endmodule

// ===== tb/sv/raid_layout_sector_map_test.sv =====
// Self-checking testbench for the RAID stripe layout sector map.
// Needs raidmap_pkg and the raid_layout_sector_map RTL; reads no files.
// A scoreboard class predicts each cell lookup; tasks drive the stream and APB ports.
module raid_layout_sector_map_test;
    timeunit 1ns;
    timeprecision 1ps;

    import raidmap_pkg::*;

    // Pipeline depth is 32 divider cells plus two stages.
    localparam int PIPE_LATENCY = 34;
    localparam int RANDOM_WORDS = 800;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [STATUS_W-1:0] status;
    } cell_result_t;

    // Predicts the cell each lookup lands on and checks the words that come out.
    class sector_map_scoreboard;
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] disks;
        logic [CHUNK_W-1:0] chunk;
        cell_result_t       expected_cells[$];
        int                 errors;

        function new();
            level  = LVL_RAID0;
            disks  = 5'd2;
            chunk  = 11'd1;
            errors = 0;
        endfunction

        function void report(string msg);
            if (errors < 100) $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_LEVEL: level = value[LEVEL_W-1:0];
                REG_DISKS: disks = value[COUNT_W-1:0];
                REG_CHUNK: chunk = value[CHUNK_W-1:0];
                default: ;
            endcase
        endfunction

        // Sector held at one cell under the current layout.
        function cell_result_t map_cell(logic [STRIPE_IN_W-1:0] stripe, logic [DISK_W-1:0] disk);
            logic [63:0]  s, d, n, c, half, pdisk, sector;
            logic [1:0]   status;
            cell_result_t res;
            s = {32'd0, stripe};
            d = {60'd0, disk};
            n = {59'd0, disks};
            c = {53'd0, chunk};
            if (n > MAX_DISKS_DEF) n = 64'(MAX_DISKS_DEF);
            if (c == 0) c = 64'd1;
            if (c > CHUNK_MAX) c = 64'(CHUNK_MAX);
            half   = n / 2;
            sector = 64'd0;
            status = ST_DATA;
            if (d >= n) begin
                status = ST_INVALID;
            end else begin
                case (level)
                    LVL_RAID0: begin
                        sector = (s / c) * n * c + s % c + c * d;
                    end
                    LVL_RAID01: begin
                        sector = s * half + ((d < half) ? d : d - half);
                    end
                    LVL_RAID10: begin
                        sector = s * half + d / 2;
                    end
                    LVL_RAID4: begin
                        if (d == n - 1) status = ST_PARITY;
                        else sector = s * (n - 1) + d;
                    end
                    LVL_RAID5: begin
                        // Left-symmetric: parity walks down from the last disk.
                        pdisk = n - 1 - (s % n);
                        if (d == pdisk) status = ST_PARITY;
                        else sector = s * (n - 1) + ((d + n - pdisk - 1) % n);
                    end
                    default: begin
                        status = ST_INVALID;
                    end
                endcase
            end
            res.sector = sector[SECTOR_W-1:0];
            res.status = status;
            return res;
        endfunction

        function void note_lookup(logic [STRIPE_IN_W-1:0] stripe, logic [DISK_W-1:0] disk);
            expected_cells.push_back(map_cell(stripe, disk));
        endfunction

        function void check_cell(logic [SECTOR_W-1:0] sector, logic [STATUS_W-1:0] status);
            cell_result_t want;
            if (expected_cells.size() == 0) begin
                report($sformatf("unexpected word sector=%0d status=%0d", sector, status));
                return;
            end
            want = expected_cells.pop_front();
            if (sector !== want.sector)
                report($sformatf("sector %0d, expected %0d", sector, want.sector));
            if (status !== want.status)
                report($sformatf("status %0d, expected %0d", status, want.status));
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [STRIPE_IN_W-1:0] s_stripe_index = '0;
    logic [DISK_W-1:0]      s_disk_index = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [SECTOR_W-1:0]    m_sector_number;
    logic [STATUS_W-1:0]    m_cell_status;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]      pwdata = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    sector_map_scoreboard sb = new();
    int send_idle_pct = 8;
    int recv_idle_pct = 50;

    raid_layout_sector_map dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stripe_index  (s_stripe_index),
        .s_disk_index    (s_disk_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sector_number (m_sector_number),
        .m_cell_status   (m_cell_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 8 ns clock.
    always begin
        #4;
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
    end

    // Result side: check each accepted word and stall at random.
    always @(posedge aclk) begin
        if (m_valid && m_ready) sb.check_cell(m_sector_number, m_cell_status);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // One register write: a setup phase, an access phase, then an idle phase.
    task automatic apb_write(logic [1:0] idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    // Present one lookup word and hold it until the block takes it.
    task automatic send_word(logic [STRIPE_IN_W-1:0] stripe, logic [DISK_W-1:0] disk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_stripe_index <= stripe;
        s_disk_index   <= disk;
        do @(posedge aclk); while (!s_ready);
        sb.note_lookup(stripe, disk);
    endtask

    // Reprogram the layout if it differs, only once the pipeline is empty.
    task automatic run_cell(logic [LEVEL_W-1:0] level, logic [COUNT_W-1:0] disks,
                            logic [CHUNK_W-1:0] chunk, logic [STRIPE_IN_W-1:0] stripe,
                            logic [DISK_W-1:0] disk);
        if (level != sb.level || disks != sb.disks || chunk != sb.chunk) begin
            s_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge aclk);
            if (level != sb.level) apb_write(REG_LEVEL, {29'd0, level});
            if (disks != sb.disks) apb_write(REG_DISKS, {27'd0, disks});
            if (chunk != sb.chunk) apb_write(REG_CHUNK, {21'd0, chunk});
        end
        send_word(stripe, disk);
    endtask

    // Random layout, with the clamped and unknown values mixed in.
    task automatic pick_layout(output logic [LEVEL_W-1:0] level,
                               output logic [COUNT_W-1:0] disks,
                               output logic [CHUNK_W-1:0] chunk);
        int pick;
        level = ($urandom_range(7) == 0) ? LEVEL_W'($urandom_range(5, 7))
                                         : LEVEL_W'($urandom_range(0, 4));
        pick = $urandom_range(9);
        case (pick)
            0:       disks = 5'd0;
            1:       disks = 5'd1;
            2:       disks = COUNT_W'($urandom_range(17, 31));
            3:       disks = 5'd16;
            default: disks = COUNT_W'($urandom_range(2, 16));
        endcase
        pick = $urandom_range(9);
        case (pick)
            0:       chunk = 11'd0;
            1:       chunk = 11'd1;
            2:       chunk = 11'd1024;
            3:       chunk = CHUNK_W'($urandom_range(1025, 2047));
            4:       chunk = CHUNK_W'($urandom_range(2, 16));
            default: chunk = CHUNK_W'($urandom_range(1, 1024));
        endcase
    endtask

    initial begin
        logic [LEVEL_W-1:0]     level;
        logic [COUNT_W-1:0]     disks;
        logic [CHUNK_W-1:0]     chunk;
        logic [STRIPE_IN_W-1:0] stripe;
        logic [DISK_W-1:0]      disk;
        int                     sent;
        int                     seg_len;
        int                     eff_disks;
        int                     kind;
        int                     waited;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset layout: two-disk raid0, chunk of one.
        run_cell(LVL_RAID0, 5'd2, 11'd1, 32'd0, 4'd0);
        run_cell(LVL_RAID0, 5'd2, 11'd1, 32'hFFFF_FFFF, 4'd1);
        run_cell(LVL_RAID0, 5'd2, 11'd1, 32'd5, 4'd15);
        // Widest raid0 and clamped count and chunk.
        run_cell(LVL_RAID0, 5'd16, 11'd1024, 32'hFFFF_FFFF, 4'd15);
        run_cell(LVL_RAID0, 5'd16, 11'd1024, 32'd1023, 4'd0);
        run_cell(LVL_RAID0, 5'd31, 11'd2047, 32'd12345, 4'd15);
        run_cell(LVL_RAID0, 5'd3, 11'd0, 32'd77, 4'd2);
        // Mirrors with an odd disk count and with a single disk.
        run_cell(LVL_RAID01, 5'd5, 11'd1, 32'd100, 4'd4);
        run_cell(LVL_RAID01, 5'd5, 11'd1, 32'd100, 4'd1);
        run_cell(LVL_RAID01, 5'd1, 11'd1, 32'd9, 4'd0);
        run_cell(LVL_RAID10, 5'd5, 11'd1, 32'd100, 4'd4);
        run_cell(LVL_RAID10, 5'd16, 11'd1, 32'hFFFF_FFFF, 4'd15);
        // Parity layouts, single disk included.
        run_cell(LVL_RAID4, 5'd1, 11'd1, 32'd7, 4'd0);
        run_cell(LVL_RAID4, 5'd16, 11'd1, 32'hFFFF_FFFF, 4'd15);
        run_cell(LVL_RAID4, 5'd16, 11'd1, 32'hFFFF_FFFF, 4'd14);
        run_cell(LVL_RAID5, 5'd1, 11'd1, 32'd3, 4'd0);
        run_cell(LVL_RAID5, 5'd16, 11'd1, 32'hFFFF_FFFF, 4'd0);
        run_cell(LVL_RAID5, 5'd16, 11'd1, 32'hFFFF_FFFF, 4'd15);
        run_cell(LVL_RAID5, 5'd5, 11'd1, 32'd2, 4'd1);
        // Unknown levels and an empty array.
        run_cell(3'd5, 5'd4, 11'd1, 32'd1, 4'd0);
        run_cell(3'd7, 5'd4, 11'd1, 32'd1, 4'd3);
        run_cell(LVL_RAID0, 5'd0, 11'd1, 32'd0, 4'd0);

        // Random segments, each under its own layout.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            pick_layout(level, disks, chunk);
            eff_disks = (disks > MAX_DISKS_DEF) ? MAX_DISKS_DEF : disks;
            seg_len = $urandom_range(20, 60);
            for (int i = 0; i < seg_len && sent < RANDOM_WORDS; i++) begin
                if (sent < RANDOM_WORDS / 3) begin
                    send_idle_pct = 8;
                    recv_idle_pct = 50;
                end else if (sent < 2 * RANDOM_WORDS / 3) begin
                    send_idle_pct = 50;
                    recv_idle_pct = 8;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                kind = $urandom_range(9);
                case (kind)
                    0:       stripe = 32'd0;
                    1:       stripe = 32'hFFFF_FFFF;
                    2, 3:    stripe = STRIPE_IN_W'($urandom_range(0, 255));
                    default: stripe = $urandom;
                endcase
                // Mostly disks inside the array, some beyond it.
                if (eff_disks > 0 && $urandom_range(99) < 85)
                    disk = DISK_W'($urandom_range(0, eff_disks - 1));
                else
                    disk = DISK_W'($urandom_range(0, 15));
                run_cell(level, disks, chunk, stripe, disk);
                sent++;
            end
        end
        s_valid <= 1'b0;

        // Drain, then watch for stray words.
        waited = 0;
        while (sb.pending() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (PIPE_LATENCY + 6) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected words never arrived", sb.pending()));

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2_000_000;
        sb.report("watchdog expired");
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/raidmap_pkg.sv
hdl/raidmap_div_cell.sv
hdl/raidmap_calc.sv
hdl/raid_layout_sector_map.sv
tb/sv/raid_layout_sector_map_test.sv
